/* hdl/lri_pkg.sv */
// ----------------------------------------------------------------------------
// lri_pkg
// Shared types and constants for the line against rectangle crossing block.
// ----------------------------------------------------------------------------
package lri_pkg;

    localparam int DIR_BITS    = 16;
    localparam int DIST_SCALE  = 100;
    localparam int RESET_LEFT  = 0;
    localparam int RESET_BOTTOM = 0;
    localparam int RESET_RIGHT = 319;
    localparam int RESET_TOP   = 239;

    typedef enum logic [1:0] {
        REG_LEFT,
        REG_BOTTOM,
        REG_RIGHT,
        REG_TOP
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EDGE_LEFT,
        EDGE_RIGHT,
        EDGE_BOTTOM,
        EDGE_TOP
    } edge_t;

    localparam int NUM_EDGES = 4;
    localparam int NUM_PAIRS = 5;

    // Pairs of edges whose crossings may need the closeness test.
    localparam edge_t PAIR_A [NUM_PAIRS] =
        '{EDGE_LEFT, EDGE_RIGHT, EDGE_LEFT, EDGE_RIGHT, EDGE_BOTTOM};
    localparam edge_t PAIR_C [NUM_PAIRS] =
        '{EDGE_BOTTOM, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP, EDGE_TOP};

    localparam int PAIR_LB = 0;
    localparam int PAIR_RB = 1;
    localparam int PAIR_LT = 2;
    localparam int PAIR_RT = 3;
    localparam int PAIR_BT = 4;

    function automatic logic edge_is_vertical(edge_t e);
        logic v;
        case (e)
            EDGE_LEFT:  v = 1'b1;
            EDGE_RIGHT: v = 1'b1;
            default:    v = 1'b0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/line_rectangle_intersection.sv */
// ----------------------------------------------------------------------------
// line_rectangle_intersection
// Finds where a line crosses the edges of a configured axis-aligned rectangle.
// ----------------------------------------------------------------------------
// The block takes one line per clock while in_stall is low and returns its
// crossings through stages 1 to 4, the divider stages, stages A to D and the
// output register. The dividers are four restoring dividers, one per rectangle
// edge, which resolve one quotient bit per pipeline stage. The pipeline halts only
// when its final stage holds a result and the output register is both full
// and stalled; otherwise input transfers continue while a result waits.
// ----------------------------------------------------------------------------
module line_rectangle_intersection
    import lri_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
)(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] base_x,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] base_y,
    input  logic signed [DIR_BITS-1:0]          dir_x,
    input  logic signed [DIR_BITS-1:0]          dir_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic                                single_hit,
    output logic signed [COORD_BITS-1:0]        first_x,
    output logic signed [COORD_BITS-1:0]        first_y,
    output logic signed [COORD_BITS-1:0]        second_x,
    output logic signed [COORD_BITS-1:0]        second_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  cfg_reg_t                            cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data
);

    localparam int QW   = COORD_BITS + FRAC_BITS;
    localparam int NW   = QW + 1;
    localparam int TNW  = QW + 2;
    localparam int DW   = DIR_BITS;
    localparam int PW   = QW + DW + 1;
    localparam int QSW  = PW + 2;
    localparam int LW   = COORD_BITS + DW + 1;
    localparam int BW   = LW + FRAC_BITS;
    localparam int RW   = QW + DW;
    localparam int NDIV = QW;
    localparam int DFW  = QW + 1;
    localparam int XSW  = FRAC_BITS + 2;
    localparam int SQW  = 2 * XSW;
    localparam int SUMW = 2 * FRAC_BITS + 2;
    localparam int SCW  = 2 * FRAC_BITS + 9;
    localparam int OW   = TNW + DW + 1;

    localparam logic signed [DFW-1:0] ONE_FX = DFW'(1) << FRAC_BITS;
    localparam logic [SCW-1:0] THRESH = SCW'(1) << (2 * FRAC_BITS);

    // Configuration.
    logic signed [COORD_BITS-1:0] left_reg, bottom_reg, right_reg, top_reg;
    logic signed [COORD_BITS-1:0] edge_pos [NUM_EDGES];

    // Pipeline control.
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, va_reg, vb_reg, vc_reg, vd_reg;
    logic div_v_reg [NDIV];

    // Stage 1.
    logic signed [QW-1:0]  pos_fx [NUM_EDGES];
    logic signed [NW-1:0]  n_next [NUM_EDGES];
    logic signed [NW-1:0]  n1_reg [NUM_EDGES];
    logic signed [QW-1:0]  bx1_reg, by1_reg;
    logic signed [DW-1:0]  dx1_reg, dy1_reg;

    // Stage 2.
    logic [DW-1:0]         adx, ady;
    logic signed [PW-1:0]  pb_next [NUM_EDGES], m_next [NUM_EDGES];
    logic signed [LW-1:0]  lo_next [NUM_EDGES], hi_next [NUM_EDGES];
    logic signed [TNW-1:0] tn2_next [NUM_EDGES];
    logic signed [PW-1:0]  pb2_reg [NUM_EDGES], m2_reg [NUM_EDGES];
    logic signed [LW-1:0]  lo2_reg [NUM_EDGES], hi2_reg [NUM_EDGES];
    logic signed [TNW-1:0] tn2_reg [NUM_EDGES];
    logic [DW-1:0]         td2_reg [NUM_EDGES];
    logic                  neg2_reg [NUM_EDGES], ok2_reg [NUM_EDGES];

    // Stage 3.
    logic signed [QSW-1:0] sum3 [NUM_EDGES];
    logic signed [QSW-1:0] q3_next [NUM_EDGES];
    logic signed [QSW-1:0] q3_reg [NUM_EDGES];
    logic signed [LW-1:0]  lo3_reg [NUM_EDGES], hi3_reg [NUM_EDGES];
    logic signed [TNW-1:0] tn3_reg [NUM_EDGES];
    logic [DW-1:0]         td3_reg [NUM_EDGES];
    logic                  ok3_reg [NUM_EDGES];

    // Stage 4.
    logic signed [BW-1:0]  lof4 [NUM_EDGES], hif4 [NUM_EDGES];
    logic signed [QSW-1:0] mag4 [NUM_EDGES];
    logic                  ok4_next [NUM_EDGES];
    logic [RW-1:0]         rem4_reg [NUM_EDGES];
    logic signed [TNW-1:0] tn4_reg [NUM_EDGES];
    logic [DW-1:0]         td4_reg [NUM_EDGES];
    logic                  ok4_reg [NUM_EDGES], neg4_reg [NUM_EDGES];

    // Divider stages.
    logic [RW-1:0]         div_rem_next [NDIV][NUM_EDGES];
    logic [QW-1:0]         div_quo_next [NDIV][NUM_EDGES];
    logic [RW-1:0]         div_rem_reg [NDIV][NUM_EDGES];
    logic [QW-1:0]         div_quo_reg [NDIV][NUM_EDGES];
    logic signed [TNW-1:0] div_tn_reg [NDIV][NUM_EDGES];
    logic [DW-1:0]         div_td_reg [NDIV][NUM_EDGES];
    logic                  div_ok_reg [NDIV][NUM_EDGES], div_neg_reg [NDIV][NUM_EDGES];

    // Stage A.
    logic signed [QW-1:0]         fa_next [NUM_EDGES];
    logic signed [COORD_BITS-1:0] ia_next [NUM_EDGES];
    logic signed [QW-1:0]         fa_reg [NUM_EDGES];
    logic signed [COORD_BITS-1:0] ia_reg [NUM_EDGES];
    logic signed [TNW-1:0]        tna_reg [NUM_EDGES];
    logic [DW-1:0]                tda_reg [NUM_EDGES];
    logic                         oka_reg [NUM_EDGES];

    // Stage B.
    logic signed [QW-1:0]         hfx [NUM_EDGES], hfy [NUM_EDGES];
    logic signed [DFW-1:0]        ex [NUM_PAIRS], ey [NUM_PAIRS];
    logic signed [XSW-1:0]        exs [NUM_PAIRS], eys [NUM_PAIRS];
    logic signed [SQW-1:0]        sqx_next [NUM_PAIRS], sqy_next [NUM_PAIRS];
    logic                         big_next [NUM_PAIRS];
    logic signed [SQW-1:0]        sqx_reg [NUM_PAIRS], sqy_reg [NUM_PAIRS];
    logic                         big_reg [NUM_PAIRS];
    logic signed [COORD_BITS-1:0] hix_reg [NUM_EDGES], hiy_reg [NUM_EDGES];
    logic signed [TNW-1:0]        tnb_reg [NUM_EDGES];
    logic [DW-1:0]                tdb_reg [NUM_EDGES];
    logic                         okb_reg [NUM_EDGES];

    // Stage C.
    logic [SCW-1:0]               dsum [NUM_PAIRS], dscaled [NUM_PAIRS];
    logic                         far [NUM_PAIRS];
    logic [1:0]                   cnt_next;
    edge_t                        i0, i1;
    logic                         far0b, far0t;
    logic [1:0]                   cntc_reg;
    logic signed [TNW-1:0]        tn0c_reg, tn1c_reg;
    logic [DW-1:0]                td0c_reg, td1c_reg;
    logic signed [COORD_BITS-1:0] x0c_reg, y0c_reg, x1c_reg, y1c_reg;

    // Stage D.
    logic signed [OW-1:0]         ordera_next, orderb_next;
    logic signed [OW-1:0]         ordera_reg, orderb_reg;
    logic [1:0]                   cntd_reg;
    logic signed [COORD_BITS-1:0] x0d_reg, y0d_reg, x1d_reg, y1d_reg;

    // Output register.
    logic                         out_valid_reg;
    logic                         found_reg, single_reg;
    logic signed [COORD_BITS-1:0] fx_reg, fy_reg, sx_reg, sy_reg;
    logic                         out_load;
    logic                         swap;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= COORD_BITS'(RESET_LEFT);
            bottom_reg <= COORD_BITS'(RESET_BOTTOM);
            right_reg  <= COORD_BITS'(RESET_RIGHT);
            top_reg    <= COORD_BITS'(RESET_TOP);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LEFT:   left_reg   <= cfg_data;
                REG_BOTTOM: bottom_reg <= cfg_data;
                REG_RIGHT:  right_reg  <= cfg_data;
                REG_TOP:    top_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        edge_pos[EDGE_LEFT]   = left_reg;
        edge_pos[EDGE_RIGHT]  = right_reg;
        edge_pos[EDGE_BOTTOM] = bottom_reg;
        edge_pos[EDGE_TOP]    = top_reg;
    end

    assign en       = !(vd_reg && out_valid_reg && out_stall);
    assign in_stall = !en;
    assign out_load = !out_valid_reg || !out_stall;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            for (int k = 0; k < NDIV; k++)
            begin
                div_v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            div_v_reg[0] <= v4_reg;
            for (int k = 1; k < NDIV; k++)
            begin
                div_v_reg[k] <= div_v_reg[k-1];
            end
            va_reg <= div_v_reg[NDIV-1];
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    // Stage 1: offset of each edge from the base point along its axis.
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            pos_fx[e] = {edge_pos[e], {FRAC_BITS{1'b0}}};
            if (edge_is_vertical(edge_t'(e)))
            begin
                n_next[e] = NW'(pos_fx[e]) - NW'(base_x);
            end
            else
            begin
                n_next[e] = NW'(pos_fx[e]) - NW'(base_y);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg  <= n_next;
            bx1_reg <= base_x;
            by1_reg <= base_y;
            dx1_reg <= dir_x;
            dy1_reg <= dir_y;
        end
    end

    // Stage 2: products.
    assign adx = dx1_reg[DW-1] ? DW'(-dx1_reg) : DW'(dx1_reg);
    assign ady = dy1_reg[DW-1] ? DW'(-dy1_reg) : DW'(dy1_reg);

    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            if (edge_is_vertical(edge_t'(e)))
            begin
                pb_next[e]  = by1_reg * dx1_reg;
                m_next[e]   = n1_reg[e] * dy1_reg;
                lo_next[e]  = bottom_reg * $signed({1'b0, adx});
                hi_next[e]  = top_reg * $signed({1'b0, adx});
                tn2_next[e] = dx1_reg[DW-1] ? -TNW'(n1_reg[e]) : TNW'(n1_reg[e]);
            end
            else
            begin
                pb_next[e]  = bx1_reg * dy1_reg;
                m_next[e]   = n1_reg[e] * dx1_reg;
                lo_next[e]  = left_reg * $signed({1'b0, ady});
                hi_next[e]  = right_reg * $signed({1'b0, ady});
                tn2_next[e] = dy1_reg[DW-1] ? -TNW'(n1_reg[e]) : TNW'(n1_reg[e]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pb2_reg <= pb_next;
            m2_reg  <= m_next;
            lo2_reg <= lo_next;
            hi2_reg <= hi_next;
            tn2_reg <= tn2_next;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                if (edge_is_vertical(edge_t'(e)))
                begin
                    td2_reg[e]  <= adx;
                    neg2_reg[e] <= dx1_reg[DW-1];
                    ok2_reg[e]  <= (dx1_reg != '0);
                end
                else
                begin
                    td2_reg[e]  <= ady;
                    neg2_reg[e] <= dy1_reg[DW-1];
                    ok2_reg[e]  <= (dy1_reg != '0);
                end
            end
        end
    end

    // Stage 3: scaled free coordinate, sign folded so the divisor is positive.
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            sum3[e]    = QSW'(pb2_reg[e]) + QSW'(m2_reg[e]);
            q3_next[e] = neg2_reg[e] ? -sum3[e] : sum3[e];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q3_reg  <= q3_next;
            lo3_reg <= lo2_reg;
            hi3_reg <= hi2_reg;
            tn3_reg <= tn2_reg;
            td3_reg <= td2_reg;
            ok3_reg <= ok2_reg;
        end
    end

    // Stage 4: inclusive bound test and magnitude for the divider.
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            lof4[e]     = {lo3_reg[e], {FRAC_BITS{1'b0}}};
            hif4[e]     = {hi3_reg[e], {FRAC_BITS{1'b0}}};
            mag4[e]     = q3_reg[e][QSW-1] ? -q3_reg[e] : q3_reg[e];
            ok4_next[e] = ok3_reg[e] && (q3_reg[e] >= QSW'(lof4[e]))
                          && (q3_reg[e] <= QSW'(hif4[e]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok4_reg <= ok4_next;
            tn4_reg <= tn3_reg;
            td4_reg <= td3_reg;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                rem4_reg[e] <= mag4[e][RW-1:0];
                neg4_reg[e] <= q3_reg[e][QSW-1];
            end
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    always_comb
    begin
        logic [RW-1:0] src_rem;
        logic [QW-1:0] src_quo;
        logic [DW-1:0] src_td;
        logic [RW-1:0] dsh;
        for (int k = 0; k < NDIV; k++)
        begin
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                if (k == 0)
                begin
                    src_rem = rem4_reg[e];
                    src_quo = '0;
                    src_td  = td4_reg[e];
                end
                else
                begin
                    src_rem = div_rem_reg[k-1][e];
                    src_quo = div_quo_reg[k-1][e];
                    src_td  = div_td_reg[k-1][e];
                end
                dsh = RW'(src_td) << (NDIV - 1 - k);
                if (src_rem >= dsh)
                begin
                    div_rem_next[k][e] = src_rem - dsh;
                    div_quo_next[k][e] = src_quo | (QW'(1) << (NDIV - 1 - k));
                end
                else
                begin
                    div_rem_next[k][e] = src_rem;
                    div_quo_next[k][e] = src_quo;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
            div_tn_reg[0]  <= tn4_reg;
            div_td_reg[0]  <= td4_reg;
            div_ok_reg[0]  <= ok4_reg;
            div_neg_reg[0] <= neg4_reg;
            for (int k = 1; k < NDIV; k++)
            begin
                div_tn_reg[k]  <= div_tn_reg[k-1];
                div_td_reg[k]  <= div_td_reg[k-1];
                div_ok_reg[k]  <= div_ok_reg[k-1];
                div_neg_reg[k] <= div_neg_reg[k-1];
            end
        end
    end

    // Stage A: signed fixed point and truncated integer crossing coordinates.
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            if (div_neg_reg[NDIV-1][e])
            begin
                fa_next[e] = -div_quo_reg[NDIV-1][e];
                ia_next[e] = -COORD_BITS'(div_quo_reg[NDIV-1][e][QW-1:FRAC_BITS]);
            end
            else
            begin
                fa_next[e] = div_quo_reg[NDIV-1][e];
                ia_next[e] = COORD_BITS'(div_quo_reg[NDIV-1][e][QW-1:FRAC_BITS]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fa_reg  <= fa_next;
            ia_reg  <= ia_next;
            tna_reg <= div_tn_reg[NDIV-1];
            tda_reg <= div_td_reg[NDIV-1];
            oka_reg <= div_ok_reg[NDIV-1];
        end
    end

    // Stage B: distance terms for every pair that may meet the closeness test.
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            if (edge_is_vertical(edge_t'(e)))
            begin
                hfx[e] = {edge_pos[e], {FRAC_BITS{1'b0}}};
                hfy[e] = fa_reg[e];
            end
            else
            begin
                hfx[e] = fa_reg[e];
                hfy[e] = {edge_pos[e], {FRAC_BITS{1'b0}}};
            end
        end
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            ex[p]  = DFW'(hfx[PAIR_A[p]]) - DFW'(hfx[PAIR_C[p]]);
            ey[p]  = DFW'(hfy[PAIR_A[p]]) - DFW'(hfy[PAIR_C[p]]);
            exs[p] = ex[p][XSW-1:0];
            eys[p] = ey[p][XSW-1:0];
            sqx_next[p] = exs[p] * exs[p];
            sqy_next[p] = eys[p] * eys[p];
            big_next[p] = (ex[p] > ONE_FX) || (ex[p] < -ONE_FX)
                          || (ey[p] > ONE_FX) || (ey[p] < -ONE_FX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            big_reg <= big_next;
            tnb_reg <= tna_reg;
            tdb_reg <= tda_reg;
            okb_reg <= oka_reg;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                if (edge_is_vertical(edge_t'(e)))
                begin
                    hix_reg[e] <= edge_pos[e];
                    hiy_reg[e] <= ia_reg[e];
                end
                else
                begin
                    hix_reg[e] <= ia_reg[e];
                    hiy_reg[e] <= edge_pos[e];
                end
            end
        end
    end

    // Stage C: closeness decisions and choice of the kept crossings.
    always_comb
    begin
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            dsum[p]    = SCW'(sqx_reg[p][SUMW-1:0]) + SCW'(sqy_reg[p][SUMW-1:0]);
            dscaled[p] = dsum[p] * SCW'(DIST_SCALE);
            far[p]     = big_reg[p] || (dscaled[p] > THRESH);
        end

        cnt_next = 2'd0;
        i0       = EDGE_LEFT;
        i1       = EDGE_RIGHT;
        if (okb_reg[EDGE_LEFT])
        begin
            i0       = EDGE_LEFT;
            cnt_next = 2'd1;
        end
        if (okb_reg[EDGE_RIGHT])
        begin
            if (cnt_next == 2'd0)
            begin
                i0 = EDGE_RIGHT;
            end
            else
            begin
                i1 = EDGE_RIGHT;
            end
            cnt_next = cnt_next + 2'd1;
        end

        far0b = (i0 == EDGE_LEFT) ? far[PAIR_LB] : far[PAIR_RB];
        if ((cnt_next != 2'd2) && okb_reg[EDGE_BOTTOM])
        begin
            if (cnt_next == 2'd0)
            begin
                i0       = EDGE_BOTTOM;
                cnt_next = 2'd1;
            end
            else if (far0b)
            begin
                i1       = EDGE_BOTTOM;
                cnt_next = 2'd2;
            end
        end

        if (i0 == EDGE_LEFT)
        begin
            far0t = far[PAIR_LT];
        end
        else if (i0 == EDGE_RIGHT)
        begin
            far0t = far[PAIR_RT];
        end
        else
        begin
            far0t = far[PAIR_BT];
        end
        if ((cnt_next != 2'd2) && okb_reg[EDGE_TOP])
        begin
            if (cnt_next == 2'd0)
            begin
                i0       = EDGE_TOP;
                cnt_next = 2'd1;
            end
            else if (far0t)
            begin
                i1       = EDGE_TOP;
                cnt_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cntc_reg <= cnt_next;
            tn0c_reg <= tnb_reg[i0];
            td0c_reg <= tdb_reg[i0];
            x0c_reg  <= hix_reg[i0];
            y0c_reg  <= hiy_reg[i0];
            tn1c_reg <= tnb_reg[i1];
            td1c_reg <= tdb_reg[i1];
            x1c_reg  <= hix_reg[i1];
            y1c_reg  <= hiy_reg[i1];
        end
    end

    // Stage D: cross products that order two crossings along the direction.
    assign ordera_next = tn1c_reg * $signed({1'b0, td0c_reg});
    assign orderb_next = tn0c_reg * $signed({1'b0, td1c_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ordera_reg <= ordera_next;
            orderb_reg <= orderb_next;
            cntd_reg   <= cntc_reg;
            x0d_reg    <= x0c_reg;
            y0d_reg    <= y0c_reg;
            x1d_reg    <= x1c_reg;
            y1d_reg    <= y1c_reg;
        end
    end

    assign swap = !(ordera_reg > orderb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            case (cntd_reg)
                2'd1:
                begin
                    found_reg  <= 1'b1;
                    single_reg <= 1'b1;
                    fx_reg     <= x0d_reg;
                    fy_reg     <= y0d_reg;
                    sx_reg     <= x0d_reg;
                    sy_reg     <= y0d_reg;
                end
                2'd2:
                begin
                    found_reg  <= 1'b1;
                    single_reg <= 1'b0;
                    fx_reg     <= swap ? x1d_reg : x0d_reg;
                    fy_reg     <= swap ? y1d_reg : y0d_reg;
                    sx_reg     <= swap ? x0d_reg : x1d_reg;
                    sy_reg     <= swap ? y0d_reg : y1d_reg;
                end
                default:
                begin
                    found_reg  <= 1'b0;
                    single_reg <= 1'b0;
                    fx_reg     <= '0;
                    fy_reg     <= '0;
                    sx_reg     <= '0;
                    sy_reg     <= '0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign single_hit = single_reg;
    assign first_x    = fx_reg;
    assign first_y    = fy_reg;
    assign second_x   = sx_reg;
    assign second_y   = sy_reg;

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> !single_hit && first_x == '0 && first_y == '0
                                && second_x == '0 && second_y == '0)
        else $error("miss result carries non-zero fields");

    a_single_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && single_hit |-> found && first_x == second_x && first_y == second_y)
        else $error("single crossing not repeated");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg |-> cntc_reg != 2'd3)
        else $error("more than two crossings kept");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> vd_reg && out_valid && out_stall)
        else $error("input stalled while the pipeline could advance");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && vd_reg |=> vd_reg && out_valid)
        else $error("result lost while output stalled");

endmodule
